// File: sv/dift_pkg.sv
// Package for the DMX interval fog trigger: command codes, controller states,
// controller-to-datapath command struct and arithmetic constants.
// No dependencies.
`default_nettype none

package dift_pkg;

   // Input transaction command codes
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_DMX    = 2'd1,
      CMD_MANUAL = 2'd2
   } req_cmd_type;

   // Controller states, one per datapath step
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_EVAL,
      ST_DIFF,
      ST_OUT
   } dift_state_type;

   // Step strobes from controller to datapath
   typedef struct packed {
      logic load_req;
      logic apply;
      logic mul1;
      logic mul2;
      logic mul3;
      logic eval;
      logic diff;
      logic load_rsp;
   } dift_cmd_type;

   localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
   localparam logic [15:0] SINCE_MAX       = 16'hFFFF;
   localparam logic [7:0]  PERCENT_MAX     = 8'd100;
   localparam int          MS_PER_S        = 1000;
   // ms per percent-second: 1000 / 100
   localparam int          PCT_SCALE       = 10;

   // floor(x / 255) = (x * DIV255_MAGIC) >> DIV255_SHIFT for x < 2^26
   localparam int          DIV255_SHIFT    = 34;
   localparam logic [26:0] DIV255_MAGIC    = 27'd67372037;
   // floor(x / 1000) = (x * DIV1000_MAGIC) >> DIV1000_SHIFT for x < 255000
   localparam int          DIV1000_SHIFT   = 28;
   localparam logic [18:0] DIV1000_MAGIC   = 19'd268436;

   // Remaining ms at or above this give the saturated countdown
   localparam logic [31:0] LEFT_SAT_DIFF   = 32'd255000;
   localparam logic [8:0]  LEFT_SAT        = 9'd256;

endpackage

`default_nettype wire

// File: sv/dift_ctrl.sv
// Controller of the DMX interval fog trigger: step sequencer and handshakes.
// Depends on dift_pkg (states, command struct).
`default_nettype none

module dift_ctrl
   import dift_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output dift_cmd_type cmd
);

   dift_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state: walk the steps, wait at the end for a free output register
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: one step strobe per state
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.load_req = req_valid;
         ST_APPLY: cmd.apply    = 1'b1;
         ST_MUL1:  cmd.mul1     = 1'b1;
         ST_MUL2:  cmd.mul2     = 1'b1;
         ST_MUL3:  cmd.mul3     = 1'b1;
         ST_EVAL:  cmd.eval     = 1'b1;
         ST_DIFF:  cmd.diff     = 1'b1;
         ST_OUT:   cmd.load_rsp = out_free;
         default:  cmd = '0;
      endcase
   end

   // Hold a result until taken, raise on load
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted transaction always starts the command step
   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_APPLY))
      else $error("accepted transaction did not enter apply step");

   // A new result only appears after the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside output step");

   // Never overwrite a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("stalled result overwritten");

   // At most one step strobe at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath step active");

endmodule

`default_nettype wire

// File: sv/dift_dpath.sv
// Datapath of the DMX interval fog trigger: timer state, on-time arithmetic,
// cycle evaluation, countdown and result register. Depends on dift_pkg.
`default_nettype none

module dift_dpath
   import dift_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dift_cmd_type cmd,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_period_seconds,
   input  wire logic [7:0]  req_duty_level,
   output logic             rsp_trigger,
   output logic             rsp_on_phase,
   output logic             rsp_dmx_mode,
   output logic             rsp_output_off,
   output logic [8:0]       rsp_seconds_left
);

   // Block state
   logic [15:0] timeout_ff,   timeout_in;
   logic [31:0] now_ff,       now_in;
   logic [31:0] cycle_end_ff, cycle_end_in;
   logic [31:0] turn_off_ff,  turn_off_in;
   logic        awaiting_ff,  awaiting_in;
   logic        trigger_ff,   trigger_in;
   logic        dmx_mode_ff,  dmx_mode_in;
   logic [7:0]  period_ff,    period_in;
   logic [7:0]  duty_ff,      duty_in;
   logic        percent_ff,   percent_in;
   logic [7:0]  last_duty_ff, last_duty_in;
   logic [15:0] since_ff,     since_in;

   // Working registers
   logic [1:0]  cmd_ff;
   logic [7:0]  per_ff;
   logic [7:0]  lvl_ff;
   logic [15:0] prod_ff;
   logic [17:0] cyc_len_ff;
   logic [25:0] scaled_ff;
   logic [17:0] on_time_ff;
   logic        off_ff,  off_in;
   logic [17:0] diff_ff;
   logic        sat_ff;

   // Arithmetic
   logic [15:0] prod_mul;
   logic [17:0] cyc_mul;
   logic [25:0] scaled_mul;
   logic [52:0] quot_mul;
   logic [17:0] pct_mul;
   logic [36:0] sec_mul;
   logic [8:0]  sec_q;
   logic [31:0] diff_full;
   logic [32:0] off_sum;
   logic        start;
   logic        past_off;
   logic        active;

   assign prod_mul   = 16'(period_ff) * 16'(duty_ff);
   assign cyc_mul    = 18'(period_ff) * 18'(MS_PER_S);
   assign scaled_mul = 26'(prod_ff) * 26'(MS_PER_S);
   assign quot_mul   = 53'(scaled_ff) * 53'(DIV255_MAGIC);
   assign pct_mul    = 18'(prod_ff) * 18'(PCT_SCALE);
   assign sec_mul    = 37'(diff_ff) * 37'(DIV1000_MAGIC);
   assign sec_q      = sec_mul[DIV1000_SHIFT +: 9];
   assign diff_full  = awaiting_ff ? (turn_off_ff - now_ff) : (cycle_end_ff - now_ff);
   assign off_sum    = {1'b0, now_ff} + 33'(on_time_ff);
   assign start      = now_ff > cycle_end_ff;
   // On a fresh start the turn-off point lies behind now only if the sum wrapped
   assign past_off   = start ? off_sum[32] : (now_ff > turn_off_ff);

   // Next values of the block state
   always_comb begin
      timeout_in   = timeout_ff;
      now_in       = now_ff;
      cycle_end_in = cycle_end_ff;
      turn_off_in  = turn_off_ff;
      awaiting_in  = awaiting_ff;
      trigger_in   = trigger_ff;
      dmx_mode_in  = dmx_mode_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      percent_in   = percent_ff;
      last_duty_in = last_duty_ff;
      since_in     = since_ff;
      off_in       = off_ff;
      active       = 1'b0;

      if (csr_wr_en) timeout_in = csr_wr_data;

      // Apply the command, then the DMX activity rules
      if (cmd.apply) begin
         unique case (cmd_ff)
            CMD_TICK: begin
               now_in = now_ff + 32'd1;
               if (since_ff != SINCE_MAX) since_in = since_ff + 16'd1;
            end
            CMD_DMX: begin
               since_in = '0;
               if (timeout_ff != 16'd0) begin
                  dmx_mode_in = 1'b1;
                  if (per_ff != period_ff) begin
                     period_in    = per_ff;
                     cycle_end_in = '0;
                     turn_off_in  = '0;
                     awaiting_in  = 1'b0;
                  end
                  if (lvl_ff != last_duty_ff) begin
                     last_duty_in = lvl_ff;
                     duty_in      = lvl_ff;
                     percent_in   = 1'b0;
                  end
               end
            end
            CMD_MANUAL: begin
               if (!dmx_mode_ff) begin
                  trigger_in = 1'b0;
                  period_in  = per_ff;
                  duty_in    = (lvl_ff > PERCENT_MAX) ? PERCENT_MAX : lvl_ff;
                  percent_in = 1'b1;
               end
            end
            default: ;
         endcase
         active = since_in < timeout_ff;
         if (!active && dmx_mode_in) trigger_in = 1'b0;
         dmx_mode_in = active;
      end

      // Evaluate the interval cycle
      if (cmd.eval) begin
         off_in = (period_ff == 8'd0) || (duty_ff == 8'd0);
         if (off_in) begin
            trigger_in = 1'b0;
         end else begin
            if (start) begin
               turn_off_in  = off_sum[31:0];
               cycle_end_in = now_ff + 32'(cyc_len_ff);
               awaiting_in  = 1'b1;
               trigger_in   = 1'b1;
            end
            if ((start || awaiting_ff) && past_off) begin
               trigger_in  = 1'b0;
               awaiting_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         now_ff       <= '0;
         cycle_end_ff <= '0;
         turn_off_ff  <= '0;
         awaiting_ff  <= 1'b0;
         trigger_ff   <= 1'b0;
         dmx_mode_ff  <= 1'b1;
         period_ff    <= '0;
         duty_ff      <= '0;
         percent_ff   <= 1'b0;
         last_duty_ff <= '0;
         since_ff     <= SINCE_MAX;
         off_ff       <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         now_ff       <= now_in;
         cycle_end_ff <= cycle_end_in;
         turn_off_ff  <= turn_off_in;
         awaiting_ff  <= awaiting_in;
         trigger_ff   <= trigger_in;
         dmx_mode_ff  <= dmx_mode_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         percent_ff   <= percent_in;
         last_duty_ff <= last_duty_in;
         since_ff     <= since_in;
         off_ff       <= off_in;
      end
   end

   // Capture the transaction and advance the arithmetic steps
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_cmd;
         per_ff <= req_period_seconds;
         lvl_ff <= req_duty_level;
      end
      if (cmd.mul1) begin
         prod_ff    <= prod_mul;
         cyc_len_ff <= cyc_mul;
      end
      if (cmd.mul2) scaled_ff <= scaled_mul;
      if (cmd.mul3) on_time_ff <= percent_ff ? pct_mul : quot_mul[DIV255_SHIFT +: 18];
      if (cmd.diff) begin
         sat_ff  <= diff_full >= LEFT_SAT_DIFF;
         diff_ff <= diff_full[17:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_trigger    <= trigger_ff;
         rsp_on_phase   <= awaiting_ff;
         rsp_dmx_mode   <= dmx_mode_ff;
         rsp_output_off <= off_ff;
         if (off_ff)      rsp_seconds_left <= '0;
         else if (sat_ff) rsp_seconds_left <= LEFT_SAT;
         else             rsp_seconds_left <= sec_q + 9'd1;
      end
   end

endmodule

`default_nettype wire

// File: sv/dmx_interval_fog_trigger.sv
// Top level of the DMX interval fog trigger: controller plus datapath.
// Depends on dift_pkg, dift_ctrl and dift_dpath.
//
//   Channel  Ports                         Handshake
//   req      req_cmd/period/duty fields    req_valid, req_stall
//   rsp      rsp_trigger ... seconds_left  rsp_valid, rsp_stall
//   csr      csr_wr_data                   csr_wr_en (no wait)
//
// Requests are stalled while a transaction runs through the fixed
// sequence of command, three multiply steps (on-time), evaluation,
// countdown difference and result load in the controller's sequencer.
// The result load waits while the previous result is still stalled.
// Synchronous active-high reset; timeout resets to 5000 ms.
`default_nettype none

module dmx_interval_fog_trigger
   import dift_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_period_seconds,
   input  wire logic [7:0]  req_duty_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_trigger,
   output logic             rsp_on_phase,
   output logic             rsp_dmx_mode,
   output logic             rsp_output_off,
   output logic [8:0]       rsp_seconds_left,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   dift_cmd_type step_cmd;

   // Sequencer
   dift_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (step_cmd)
   );

   // State and arithmetic
   dift_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (step_cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_cmd),
      .req_period_seconds (req_period_seconds),
      .req_duty_level     (req_duty_level),
      .rsp_trigger        (rsp_trigger),
      .rsp_on_phase       (rsp_on_phase),
      .rsp_dmx_mode       (rsp_dmx_mode),
      .rsp_output_off     (rsp_output_off),
      .rsp_seconds_left   (rsp_seconds_left)
   );

endmodule

`default_nettype wire

// File: tb/dift_fog_checker.sv
// Checker for the DMX interval fog trigger: predicts every result from the
// accepted request transactions and compares it with the response channel.
// Depends on dift_pkg; instantiated beside the block by the testbench top.
module dift_fog_checker
   import dift_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_period_seconds,
   input  logic [7:0]  req_duty_level,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_trigger,
   input  logic        rsp_on_phase,
   input  logic        rsp_dmx_mode,
   input  logic        rsp_output_off,
   input  logic [8:0]  rsp_seconds_left,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          pending_count,
   output int          error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       trigger;
      logic       on_phase;
      logic       dmx_mode;
      logic       output_off;
      logic [8:0] seconds_left;
   } fog_status_type;

   fog_status_type fog_status_q[$];
   int             mismatches = 0;

   // Timer state of the trigger, mirrored from the accepted transactions
   logic [15:0] timeout_ms;
   logic [31:0] clock_ms;
   logic [31:0] cycle_end_ms;
   logic [31:0] fog_off_ms;
   logic        waiting_off;
   logic        fog_on;
   logic        in_dmx;
   logic [7:0]  period_s;
   logic [7:0]  duty_num;
   logic        duty_pct;
   logic [7:0]  prev_dmx_duty;
   logic [15:0] quiet_ms;

   // Apply one command, then evaluate the cycle and return the status
   function automatic fog_status_type step_fog_trigger(input logic [1:0] cmd,
                                                       input logic [7:0] per,
                                                       input logic [7:0] duty);
      fog_status_type st;
      logic           active;
      logic [31:0]    on_ms;
      logic [31:0]    remain_ms;
      logic [31:0]    secs;
      st = '0;
      case (cmd)
         CMD_TICK: begin
            clock_ms = clock_ms + 32'd1;
            if (quiet_ms != SINCE_MAX)
               quiet_ms = quiet_ms + 16'd1;
         end
         CMD_DMX: begin
            quiet_ms = '0;
            // a zero timeout never lets a frame through
            if (quiet_ms < timeout_ms) begin
               in_dmx = 1'b1;
               if (per != period_s) begin
                  period_s     = per;
                  cycle_end_ms = '0;
                  fog_off_ms   = '0;
                  waiting_off  = 1'b0;
               end
               if (duty != prev_dmx_duty) begin
                  prev_dmx_duty = duty;
                  duty_num      = duty;
                  duty_pct      = 1'b0;
               end
            end
         end
         CMD_MANUAL: begin
            if (!in_dmx) begin
               fog_on   = 1'b0;
               period_s = per;
               duty_num = (duty > PERCENT_MAX) ? PERCENT_MAX : duty;
               duty_pct = 1'b1;
            end
         end
         default: ;
      endcase

      // Fall back to manual mode on silence, return to DMX on activity
      active = (quiet_ms < timeout_ms);
      if (!active && in_dmx) begin
         in_dmx = 1'b0;
         fog_on = 1'b0;
      end
      if (active && !in_dmx)
         in_dmx = 1'b1;

      if (period_s == 8'd0 || duty_num == 8'd0) begin
         fog_on        = 1'b0;
         st.output_off = 1'b1;
      end else begin
         if (clock_ms > cycle_end_ms) begin
            on_ms        = 32'(duty_num) * 32'(period_s) * MS_PER_S;
            on_ms        = duty_pct ? on_ms / 32'd100 : on_ms / 32'd255;
            fog_off_ms   = clock_ms + on_ms;
            cycle_end_ms = clock_ms + 32'(period_s) * MS_PER_S;
            waiting_off  = 1'b1;
            fog_on       = 1'b1;
         end
         if (waiting_off && clock_ms > fog_off_ms) begin
            fog_on      = 1'b0;
            waiting_off = 1'b0;
         end
         remain_ms = waiting_off ? fog_off_ms - clock_ms : cycle_end_ms - clock_ms;
         secs      = remain_ms / MS_PER_S + 32'd1;
         st.seconds_left = (secs > 32'(LEFT_SAT)) ? LEFT_SAT : secs[8:0];
      end
      st.trigger  = fog_on;
      st.on_phase = waiting_off;
      st.dmx_mode = in_dmx;
      return st;
   endfunction

   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Track config writes, predict on requests, compare on responses
   always @(posedge clock) begin
      fog_status_type want;
      if (reset) begin
         fog_status_q.delete();
         timeout_ms    = TIMEOUT_RESET;
         clock_ms      = '0;
         cycle_end_ms  = '0;
         fog_off_ms    = '0;
         waiting_off   = 1'b0;
         fog_on        = 1'b0;
         in_dmx        = 1'b1;
         period_s      = '0;
         duty_num      = '0;
         duty_pct      = 1'b0;
         prev_dmx_duty = '0;
         quiet_ms      = SINCE_MAX;
      end else begin
         if (csr_wr_en)
            timeout_ms = csr_wr_data;
         if (req_valid && !req_stall)
            fog_status_q.push_back(step_fog_trigger(req_cmd, req_period_seconds,
                                                    req_duty_level));
         if (rsp_valid && !rsp_stall) begin
            if (fog_status_q.size() == 0) begin
               mismatches++;
               $error("response transaction with no expected status");
            end else begin
               want = fog_status_q.pop_front();
               check_field("trigger", 9'(want.trigger), 9'(rsp_trigger));
               check_field("on_phase", 9'(want.on_phase), 9'(rsp_on_phase));
               check_field("dmx_mode", 9'(want.dmx_mode), 9'(rsp_dmx_mode));
               check_field("output_off", 9'(want.output_off), 9'(rsp_output_off));
               check_field("seconds_left", want.seconds_left, rsp_seconds_left);
            end
         end
      end
      pending_count <= fog_status_q.size();
      error_count   <= mismatches;
   end

endmodule

// File: tb/dmx_interval_fog_trigger_test.sv
// Testbench top for the DMX interval fog trigger: clock, reset, stimulus on
// the request, response and register ports, and the final verdict.
// Depends on dift_pkg, dmx_interval_fog_trigger and dift_fog_checker.
module dmx_interval_fog_trigger_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dift_pkg::*;

   localparam int         CLK_PERIOD       = 8;
   localparam int         RESET_CYCLES     = 9;
   localparam int         SETTLE_CYCLES    = 16;
   localparam int         RANDOM_PER_PHASE = 60;
   localparam int         LONG_RUN_TICKS   = 40;
   localparam int         RUN_LIMIT_NS     = 1_000_000;
   localparam logic [1:0] CMD_UNUSED       = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_period_seconds;
   logic [7:0]  req_duty_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_trigger;
   logic        rsp_on_phase;
   logic        rsp_dmx_mode;
   logic        rsp_output_off;
   logic [8:0]  rsp_seconds_left;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          pending_count;
   int          error_count;

   int          items_sent  = 0;
   bit          steady_flow = 1'b0;

   dmx_interval_fog_trigger u_dut (.*);

   dift_fog_checker u_fog_check (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Send one request transaction, after a random gap unless the flow is steady
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] per,
                            input logic [7:0] duty);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_period_seconds <= per;
      req_duty_level     <= duty;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Hold the sender until every expected status has come back
   task automatic hold_until_drained(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_period();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return 8'd0;
      if (r == 1)
         return 8'd255;
      if (r == 2)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(1, 3));
   endfunction

   // Write the timeout while idle, then run random episodes
   task automatic run_phase(input logic [15:0] timeout_ms, input bit steady);
      int         stop_at;
      int         kind;
      int         len;
      logic [7:0] per;
      logic [7:0] duty;
      hold_until_drained(1'b1);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= timeout_ms;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      steady_flow = steady;

      // Restart the cycle at one second and tick past the turn-off point
      if (timeout_ms == SINCE_MAX) begin
         send_item(CMD_DMX, 8'd0, 8'd77);
         send_item(CMD_DMX, 8'd1, 8'd3);
         repeat (LONG_RUN_TICKS) send_item(CMD_TICK, 8'($urandom), 8'($urandom));
      end

      stop_at = items_sent + RANDOM_PER_PHASE;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 9);
         per  = pick_period();
         duty = 8'($urandom_range(0, 255));
         if (kind < 5) begin
            // DMX frame followed by ticks, with repeated or changed frames
            send_item(CMD_DMX, per, duty);
            len = $urandom_range(1, 30);
            repeat (len) begin
               if ($urandom_range(0, 7) == 0)
                  send_item(CMD_DMX, per,
                            ($urandom_range(0, 1) == 1) ? duty : 8'($urandom));
               else
                  send_item(CMD_TICK, 8'($urandom), 8'($urandom));
            end
         end else if (kind < 8) begin
            // Let the packets lapse, then set manual values and tick
            len = $urandom_range(1, 40);
            repeat (len) send_item(CMD_TICK, 8'($urandom), 8'($urandom));
            duty = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(101, 255))
                                                : 8'($urandom_range(0, 100));
            send_item(CMD_MANUAL, per, duty);
            len = $urandom_range(1, 20);
            repeat (len) send_item(CMD_TICK, 8'($urandom), 8'($urandom));
         end else begin
            // Noise: any command code, any field values
            len = $urandom_range(1, 6);
            repeat (len)
               send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
         if ($urandom_range(0, 7) == 0)
            hold_until_drained(1'b0);
      end
      steady_flow = 1'b0;
   endtask

   // Response side: stall each status for a random number of cycles
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (gap - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Stimulus and verdict
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = CMD_TICK;
      req_period_seconds = '0;
      req_duty_level     = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Quiet timer starts saturated, so the first evaluation drops to manual
      send_item(CMD_TICK, 8'h00, 8'h00);
      send_item(CMD_TICK, 8'hFF, 8'hFF);
      // Zero period, then zero duty: output disabled
      send_item(CMD_MANUAL, 8'd0, 8'd50);
      send_item(CMD_MANUAL, 8'd1, 8'd0);
      // Percent above 100 clamps; a cycle starts at once
      send_item(CMD_MANUAL, 8'd1, 8'd255);
      send_item(CMD_TICK, 8'h55, 8'hAA);
      send_item(CMD_TICK, 8'hAA, 8'h55);
      send_item(CMD_UNUSED, 8'hFF, 8'hFF);
      send_item(CMD_MANUAL, 8'd255, 8'd100);
      // Frames switch to DMX mode at the longest period and take the DMX duty
      send_item(CMD_DMX, 8'd255, 8'd255);
      send_item(CMD_DMX, 8'd255, 8'd255);
      // Manual values are dropped in DMX mode
      send_item(CMD_MANUAL, 8'd7, 8'd30);
      send_item(CMD_DMX, 8'd0, 8'd128);
      send_item(CMD_DMX, 8'd3, 8'd0);
      // Shortest on-time, then tick past turn-off
      send_item(CMD_DMX, 8'd1, 8'd1);
      repeat (4) send_item(CMD_TICK, 8'h00, 8'hFF);
      send_item(CMD_DMX, 8'd170, 8'd85);
      send_item(CMD_TICK, 8'h0F, 8'hF0);
      send_item(CMD_UNUSED, 8'd0, 8'd0);

      run_phase(16'd1, 1'b0);
      run_phase(SINCE_MAX, 1'b0);
      run_phase(16'd0, 1'b0);
      run_phase(16'($urandom_range(2, 40)), 1'b1);
      run_phase(16'($urandom_range(41, 600)), 1'b0);
      run_phase(16'($urandom), 1'b0);
      hold_until_drained(1'b1);

      if (error_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: dmx_interval_fog_trigger.f
sv/dift_pkg.sv
sv/dift_ctrl.sv
sv/dift_dpath.sv
sv/dmx_interval_fog_trigger.sv
tb/dift_fog_checker.sv
tb/dmx_interval_fog_trigger_test.sv
